### src/hrs_pkg.sv
// Package for the histogram range selectivity core.
// Holds the item structs, command and status codes and the offset-binary helper.
// No dependencies.
package hrs_pkg;

    localparam int VW    = 32;   // boundary and range value width
    localparam int QB    = 16;   // fraction bits produced by the overlap divider
    localparam int IDXW  = 11;   // wide enough for any bucket index up to 1024
    localparam int CNTW  = 5;    // counts the steps of the build divider
    localparam int SELW  = 17;
    localparam logic [SELW-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;
    localparam logic [1:0] CMD_INTER = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_HIST = 2'd1;
    localparam logic [1:0] ST_NON_MON = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [7:0]           bucket_index;
        logic signed [VW-1:0] boundary_value;
        logic signed [VW-1:0] range_min;
        logic signed [VW-1:0] range_max;
        logic signed [VW-1:0] lower_a;
        logic signed [VW-1:0] upper_a;
        logic signed [VW-1:0] lower_b;
        logic signed [VW-1:0] upper_b;
        logic                 need_histogram;
    } t_hrs_in;

    typedef struct packed {
        logic [SELW-1:0] selectivity;
        logic [1:0]      status;
        logic            ready_res;
    } t_hrs_out;

    // Classified command as it waits in the queue; values are offset binary.
    typedef struct packed {
        logic [1:0]    cmd;
        logic [7:0]    idx;
        logic [VW-1:0] val;
        logic [VW-1:0] lo;
        logic [VW-1:0] hi;
        logic          empty;
        logic          need;
    } t_hrs_job;

    typedef struct packed {
        logic     valid;
        t_hrs_job job;
    } t_hrs_fq;

    // Offset binary: unsigned order matches signed order.
    function automatic logic [VW-1:0] f_bias(input logic [VW-1:0] v);
        f_bias = {~v[VW-1], v[VW-2:0]};
    endfunction

endpackage

### src/hrs_front.sv
// Front end: accepts command items, swaps and intersects ranges, and queues them.
// Depends on hrs_pkg.
module hrs_front import hrs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_hrs_in  i_item,
    input  logic     i_pop,
    output logic     busy,
    output t_hrs_fq  o_fq
);

    t_hrs_job      r_q [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    t_hrs_job      w_job;
    logic          w_push;
    logic [VW-1:0] w_la, w_ua, w_lb, w_ub, w_a0, w_a1, w_b0, w_b1, w_mn, w_mx;

    assign busy   = (r_cnt == 2'd2);
    assign w_push = start && !busy;

    always_comb begin
        w_la = f_bias(i_item.lower_a);
        w_ua = f_bias(i_item.upper_a);
        w_lb = f_bias(i_item.lower_b);
        w_ub = f_bias(i_item.upper_b);
        w_mn = f_bias(i_item.range_min);
        w_mx = f_bias(i_item.range_max);
        w_a0 = (w_ua < w_la) ? w_ua : w_la;
        w_a1 = (w_ua < w_la) ? w_la : w_ua;
        w_b0 = (w_ub < w_lb) ? w_ub : w_lb;
        w_b1 = (w_ub < w_lb) ? w_lb : w_ub;
        w_job.cmd   = i_item.cmd;
        w_job.idx   = i_item.bucket_index;
        w_job.val   = f_bias(i_item.boundary_value);
        w_job.need  = i_item.need_histogram;
        w_job.empty = 1'b0;
        w_job.lo    = w_a0;
        w_job.hi    = w_a1;
        unique case (i_item.cmd)
            CMD_BUILD: begin
                w_job.lo = (w_mx < w_mn) ? w_mx : w_mn;
                w_job.hi = (w_mx < w_mn) ? w_mn : w_mx;
            end
            CMD_INTER: begin
                w_job.lo    = (w_a0 > w_b0) ? w_a0 : w_b0;
                w_job.hi    = (w_a1 < w_b1) ? w_a1 : w_b1;
                w_job.empty = !(w_job.hi > w_job.lo);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    assign o_fq.valid = (r_cnt != 2'd0);
    assign o_fq.job   = r_q[r_rp];

endmodule

### src/hrs_div.sv
// Pipelined restoring divider: floor(o * 2^16 / w) for o <= w, one bit per stage.
// Depends on hrs_pkg.
module hrs_div import hrs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [VW-1:0]   i_o,
    input  logic [VW-1:0]   i_w,
    output logic            o_valid,
    output logic [SELW-1:0] o_quo,
    output logic            o_busy
);

    logic [QB:0]   r_v;
    logic [VW:0]   r_r [0:QB];
    logic [VW-1:0] r_w [0:QB];
    logic [QB-1:0] r_q [0:QB];
    logic [QB:0]   r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QB-1:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        r_r[0] <= {1'b0, i_o};
        r_w[0] <= i_w;
        r_q[0] <= '0;
        r_f[0] <= (i_o >= i_w);
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [VW:0] w_sh;
        logic        w_ge;
        // The remainder stays at or below w, so its top bit is always clear.
        assign w_sh = {r_r[k][VW-1:0], 1'b0};
        assign w_ge = (w_sh >= {1'b0, r_w[k]});
        always_ff @(posedge i_clk) begin
            r_r[k+1] <= w_ge ? (w_sh - {1'b0, r_w[k]}) : w_sh;
            r_q[k+1] <= {r_q[k][QB-2:0], w_ge};
            r_w[k+1] <= r_w[k];
            r_f[k+1] <= r_f[k];
        end
    end

    assign o_valid = r_v[QB];
    assign o_quo   = r_f[QB] ? ONE_Q16 : {1'b0, r_q[QB]};
    assign o_busy  = |r_v;

endmodule

### src/hrs_back.sv
// Back end: boundary store, uniform build sequencer and the two-pass query walk.
// Depends on hrs_pkg and hrs_div.
module hrs_back import hrs_pkg::*; #(
    parameter int BUCKETS = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_hrs_fq  i_fq,
    output logic     o_pop,
    output t_hrs_out o_res,
    output logic     o_stb
);

    localparam int AW   = $clog2(BUCKETS + 1);
    localparam int LB   = $clog2(BUCKETS);
    localparam int NS   = SELW + LB;
    localparam int RW   = SELW + 2;
    localparam int PW   = SELW + RW;
    localparam int BS   = VW + LB;
    localparam int PBW  = 2 * VW + 1;
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << NS) + BUCKETS - 1) / BUCKETS);
    localparam logic [VW:0]   RECB  = (VW+1)'(((64'd1 << BS) + BUCKETS - 1) / BUCKETS);
    localparam logic [AW-1:0] LAST  = AW'(BUCKETS);
    localparam logic [VW-1:0] ZERO_B = {1'b1, {(VW-1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BDIV  = 3'd1;
    localparam logic [2:0] S_BUILD = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_CLIP  = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;

    logic [VW-1:0]   r_mem [0:BUCKETS];
    logic [BUCKETS:0] r_vld;
    logic [VW-1:0]   r_rd;
    logic            r_rv;
    logic [AW-1:0]   r_ri;

    logic [2:0]      r_state;
    logic            r_ready;
    t_hrs_job        r_job;
    logic [AW-1:0]   r_i;
    logic            r_iss;
    logic [CNTW-1:0] r_cnt;
    logic [VW-1:0]   r_dvd;
    logic [PBW-1:0]  r_bp;
    logic [AW-1:0]   r_rem;
    logic [AW:0]     r_rr;
    logic [VW-1:0]   r_acc;
    logic [VW-1:0]   r_prev;
    logic [VW-1:0]   r_first;
    logic [VW-1:0]   r_last;
    logic            r_bad;
    logic [VW-1:0]   r_lo;
    logic [VW-1:0]   r_hi;
    logic            r_mv;
    logic [PW-1:0]   r_mp;
    logic [SELW:0]   r_sum;
    t_hrs_out        r_res;
    logic            r_stb;

    logic            w_we;
    logic [AW-1:0]   w_wa;
    logic [VW-1:0]   w_wd;
    logic [IDXW-1:0] w_idx;
    logic            w_take;
    logic            w_issue;
    logic [VW-1:0]   w_bq;
    logic [VW-1:0]   w_bm;
    logic [AW:0]     w_rsum;
    logic [VW-1:0]   w_ol, w_oh;
    logic            w_push;
    logic            w_dv;
    logic [SELW-1:0] w_dq;
    logic            w_dbusy;
    logic [PW-1:0]   w_msh;
    logic [VW-1:0]   w_clo, w_chi;

    assign w_take  = (r_state == S_IDLE) && i_fq.valid;
    assign o_pop   = w_take;
    assign w_idx   = IDXW'(i_fq.job.idx);
    assign w_issue = r_iss && ((r_state == S_CHECK) || (r_state == S_SUM));
    assign w_bq    = VW'(r_bp >> BS);
    assign w_bm    = w_bq * VW'(BUCKETS);
    assign w_rsum  = r_rr + {1'b0, r_rem};
    assign w_msh   = r_mp >> NS;
    assign w_clo   = (r_job.lo < r_first) ? r_first : r_job.lo;
    assign w_chi   = (r_job.hi > r_last) ? r_last : r_job.hi;

    // Write port: single boundary writes and the build sweep share it.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_i;
        w_wd = r_job.lo + r_acc;
        if (w_take && (i_fq.job.cmd == CMD_WRITE) && (w_idx <= IDXW'(BUCKETS))) begin
            w_we = 1'b1;
            w_wa = w_idx[AW-1:0];
            w_wd = i_fq.job.val;
        end else if (r_state == S_BUILD) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_issue) begin
            r_rd <= r_vld[r_i] ? r_mem[r_i] : ZERO_B;
        end
        r_ri <= r_i;
    end

    // Overlap of the clipped range with the bucket ending at the entry just read.
    always_comb begin
        w_ol   = (r_lo > r_prev) ? r_lo : r_prev;
        w_oh   = (r_hi < r_rd) ? r_hi : r_rd;
        w_push = (r_state == S_SUM) && r_rv && (r_ri != '0) && (r_rd > r_prev) && (w_oh > w_ol);
    end

    hrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_o     (w_oh - w_ol),
        .i_w     (r_rd - r_prev),
        .o_valid (w_dv),
        .o_quo   (w_dq),
        .o_busy  (w_dbusy)
    );

    always_ff @(posedge i_clk) begin
        r_mp <= PW'(w_dq) * PW'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_vld   <= '0;
            r_stb   <= 1'b0;
            r_rv    <= 1'b0;
            r_iss   <= 1'b0;
            r_mv    <= 1'b0;
        end else begin
            r_stb <= 1'b0;
            r_rv  <= w_issue;
            r_mv  <= w_dv;
            if (w_we) begin
                r_vld[w_wa] <= 1'b1;
            end
            if (w_issue) begin
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_iss <= 1'b0;
                end
            end
            if (r_mv) begin
                r_sum <= r_sum + (SELW+1)'(w_msh);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_job           <= i_fq.job;
                        r_res.selectivity <= '0;
                        r_res.status    <= ST_OK;
                        r_sum           <= '0;
                        r_bad           <= 1'b0;
                        r_i             <= '0;
                        unique case (i_fq.job.cmd)
                            CMD_WRITE: begin
                                r_stb           <= 1'b1;
                                r_res.ready_res <= r_ready || (w_idx == IDXW'(BUCKETS));
                                if (w_idx == IDXW'(BUCKETS)) begin
                                    r_ready <= 1'b1;
                                end
                            end
                            CMD_BUILD: begin
                                r_dvd   <= i_fq.job.hi - i_fq.job.lo;
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_BDIV;
                            end
                            default: begin
                                r_res.ready_res <= r_ready;
                                if ((i_fq.job.cmd == CMD_INTER) && i_fq.job.empty) begin
                                    r_stb <= 1'b1;
                                end else if (!r_ready) begin
                                    r_stb <= 1'b1;
                                    if (i_fq.job.need) begin
                                        r_res.status <= ST_NO_HIST;
                                    end else begin
                                        r_res.selectivity <= ONE_Q16;
                                    end
                                end else begin
                                    r_iss   <= 1'b1;
                                    r_state <= S_CHECK;
                                end
                            end
                        endcase
                    end
                end
                S_BDIV: begin
                    // Span over the bucket count: a reciprocal multiply gives the
                    // quotient, then one multiply and subtract gives the remainder.
                    if (r_cnt == '0) begin
                        r_bp  <= PBW'(r_dvd) * PBW'(RECB);
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_dvd   <= w_bq;
                        r_rem   <= AW'(r_dvd - w_bm);
                        r_acc   <= '0;
                        r_rr    <= '0;
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    // acc tracks floor(span * i / BUCKETS) as quotient plus carried remainder.
                    if (w_rsum >= (AW+1)'(BUCKETS)) begin
                        r_rr  <= w_rsum - (AW+1)'(BUCKETS);
                        r_acc <= r_acc + r_dvd + 1'b1;
                    end else begin
                        r_rr  <= w_rsum;
                        r_acc <= r_acc + r_dvd;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST) begin
                        r_ready         <= 1'b1;
                        r_res.ready_res <= 1'b1;
                        r_stb           <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    if (r_rv) begin
                        r_prev <= r_rd;
                        if (r_ri == '0) begin
                            r_first <= r_rd;
                        end else if (r_rd < r_prev) begin
                            r_bad <= 1'b1;
                        end
                        if (r_ri == LAST) begin
                            r_last  <= r_rd;
                            r_state <= S_CLIP;
                        end
                    end
                end
                S_CLIP: begin
                    r_lo <= w_clo;
                    r_hi <= w_chi;
                    r_i  <= '0;
                    if (r_bad) begin
                        r_res.status <= ST_NON_MON;
                        r_stb        <= 1'b1;
                        r_state      <= S_IDLE;
                    end else if (!(w_chi > w_clo)) begin
                        r_stb   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_iss   <= 1'b1;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_rv) begin
                        r_prev <= r_rd;
                        if (r_ri == LAST) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!w_dbusy && !r_mv) begin
                        r_res.selectivity <= (r_sum > (SELW+1)'(ONE_Q16)) ?
                                             ONE_Q16 : r_sum[SELW-1:0];
                        r_stb   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res = r_res;
    assign o_stb = r_stb;

endmodule

### src/histogram_range_selectivity_core.sv
// A uniform build writes every boundary in one sweep; a full query makes two
// sweeps over the single read port of the boundary store.
// Throughput: one command at a time in the back end; a two-entry queue takes
// commands while it works. Reset (synchronous, active low) empties the queue,
// clears the ready flag and marks every boundary as zero. Results cannot be stalled.
module histogram_range_selectivity_core import hrs_pkg::*; #(
    parameter int BUCKETS = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_hrs_in  i_item,
    output logic     busy,
    output t_hrs_out o_result,
    output logic     o_strobe
);

    // Queue head and the handshake that removes it.
    t_hrs_fq w_fq;
    logic    w_pop;

    // The front end swaps reversed bounds and forms the intersection of two
    // ranges, so the back end only ever sees one ordered range per query.
    hrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .i_pop   (w_pop),
        .busy    (busy),
        .o_fq    (w_fq)
    );

    // The back end owns the boundary store. A query first walks all entries to
    // check that they never decrease and to find the outer bounds, then walks
    // them again feeding each bucket overlap into a pipelined divider.
    hrs_back #(
        .BUCKETS (BUCKETS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fq    (w_fq),
        .o_pop   (w_pop),
        .o_res   (o_result),
        .o_stb   (o_strobe)
    );

endmodule
